/* sv/b64d_pkg.sv */
// b64d_pkg: shared types, codes and the alphabet lookup for the base64url decoder.
// No dependencies; every decoder module refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

    localparam int CHAR_W   = 8;
    localparam int DIGIT_W  = 6;
    localparam int ACC_W    = 12;
    localparam int HELD_W   = 4;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;

    localparam logic [CHAR_W-1:0] CHAR_PAD = 8'h3D;  // '='

    // Final status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 3'd0,
        STATUS_BAD_LEN   = 3'd1,
        STATUS_PAD_INNER = 3'd2,
        STATUS_BAD_CHAR  = 3'd3,
        STATUS_PAD_BITS  = 3'd4
    } status_t;

    // Sticky per-string character error
    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_PAD_INNER = 2'd1,
        ERR_BAD_CHAR  = 2'd2
    } char_err_t;

    // One input request
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              is_last;
    } item_t;

    // One result request
    typedef struct packed {
        logic                byte_valid;
        logic [BYTE_W-1:0]   data_byte;
        logic                done_res;
        logic [STATUS_W-1:0] status;
    } result_t;

    // Alphabet lookup: {miss, digit}; miss set for anything outside A-Z a-z 0-9 - _
    function automatic logic [DIGIT_W:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [DIGIT_W:0] r;
        r = {1'b1, {DIGIT_W{1'b0}}};
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b0, DIGIT_W'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b0, DIGIT_W'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, DIGIT_W'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2D) begin
            r = {1'b0, DIGIT_W'(62)};
        end else if (c == 8'h5F) begin
            r = {1'b0, DIGIT_W'(63)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/b64d_in_stage.sv */
// b64d_in_stage: input register of the decoder pipeline.
// Depends on b64d_pkg (item_t).
`timescale 1ns / 1ps
`default_nettype none

module b64d_in_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire b64d_pkg::item_t s_item,
    input  wire logic          advance,
    output logic               item_valid,
    output b64d_pkg::item_t    item
);

    logic            valid_reg, valid_next;
    b64d_pkg::item_t item_reg;

    // Free slot, or the held request moves on this cycle
    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

/* sv/b64d_step.sv */
// b64d_step: decode state and the per-character next-state / result logic.
// Depends on b64d_pkg (item_t, result_t, codes, digit_of).
`timescale 1ns / 1ps
`default_nettype none

module b64d_step (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step_en,
    input  wire b64d_pkg::item_t item,
    output b64d_pkg::result_t    result
);

    logic [b64d_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [b64d_pkg::HELD_W-1:0] held_reg, held_next;
    logic [1:0]                  len_reg, len_next;
    logic [1:0]                  pads_reg, pads_next;
    logic                        pad_seen_reg, pad_seen_next;
    b64d_pkg::char_err_t         err_reg, err_next;

    logic [b64d_pkg::DIGIT_W:0]  dig;
    logic                        is_pad;
    logic [b64d_pkg::ACC_W-1:0]  acc_upd;
    logic [b64d_pkg::HELD_W-1:0] held_sum;
    logic [b64d_pkg::HELD_W-1:0] held_upd;
    logic [b64d_pkg::ACC_W-1:0]  pad_mask;
    logic                        byte_out;
    logic [b64d_pkg::BYTE_W-1:0] byte_val;
    b64d_pkg::status_t           status_val;

    always_comb begin
        is_pad   = (item.char_code == b64d_pkg::CHAR_PAD);
        dig      = b64d_pkg::digit_of(item.char_code);
        acc_upd  = {acc_reg[b64d_pkg::ACC_W-b64d_pkg::DIGIT_W-1:0],
                    dig[b64d_pkg::DIGIT_W-1:0]};
        held_sum = held_reg + b64d_pkg::HELD_W'(b64d_pkg::DIGIT_W);
        held_upd = held_sum;
        byte_out = 1'b0;
        byte_val = '0;

        acc_next      = acc_reg;
        held_next     = held_reg;
        len_next      = len_reg;
        pads_next     = pads_reg;
        pad_seen_next = pad_seen_reg;
        err_next      = err_reg;

        if (is_pad) begin
            pads_next     = pads_reg + 2'd1;
            pad_seen_next = 1'b1;
        end else begin
            // interior '=' run counts toward length
            len_next      = len_reg + pads_reg + 2'd1;
            pads_next     = 2'd0;
            pad_seen_next = 1'b0;
            if (pad_seen_reg && err_next == b64d_pkg::ERR_NONE) begin
                err_next = b64d_pkg::ERR_PAD_INNER;
            end
            if (dig[b64d_pkg::DIGIT_W] && err_next == b64d_pkg::ERR_NONE) begin
                err_next = b64d_pkg::ERR_BAD_CHAR;
            end
            if (err_next == b64d_pkg::ERR_NONE) begin
                acc_next = acc_upd;
                if (held_sum >= b64d_pkg::HELD_W'(b64d_pkg::BYTE_W)) begin
                    held_upd = held_sum - b64d_pkg::HELD_W'(b64d_pkg::BYTE_W);
                    byte_out = 1'b1;
                    byte_val = b64d_pkg::BYTE_W'(acc_upd >> held_upd);
                end
                held_next = held_upd;
            end
        end

        pad_mask   = (b64d_pkg::ACC_W'(1) << held_next) - b64d_pkg::ACC_W'(1);
        status_val = b64d_pkg::STATUS_OK;
        if (item.is_last) begin
            if (len_next == 2'd1) begin
                status_val = b64d_pkg::STATUS_BAD_LEN;
            end else if (err_next == b64d_pkg::ERR_PAD_INNER) begin
                status_val = b64d_pkg::STATUS_PAD_INNER;
            end else if (err_next == b64d_pkg::ERR_BAD_CHAR) begin
                status_val = b64d_pkg::STATUS_BAD_CHAR;
            end else if (held_next != '0 && (acc_next & pad_mask) != '0) begin
                status_val = b64d_pkg::STATUS_PAD_BITS;
            end
        end

        result.byte_valid = byte_out;
        result.data_byte  = byte_val;
        result.done_res   = item.is_last;
        result.status     = status_val;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            held_reg     <= '0;
            len_reg      <= '0;
            pads_reg     <= '0;
            pad_seen_reg <= 1'b0;
            err_reg      <= b64d_pkg::ERR_NONE;
        end else if (step_en) begin
            if (item.is_last) begin
                acc_reg      <= '0;
                held_reg     <= '0;
                len_reg      <= '0;
                pads_reg     <= '0;
                pad_seen_reg <= 1'b0;
                err_reg      <= b64d_pkg::ERR_NONE;
            end else begin
                acc_reg      <= acc_next;
                held_reg     <= held_next;
                len_reg      <= len_next;
                pads_reg     <= pads_next;
                pad_seen_reg <= pad_seen_next;
                err_reg      <= err_next;
            end
        end
    end

    // Held bit count is always 0, 2, 4 or 6
    a_held_range: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= b64d_pkg::HELD_W'(6) && !held_reg[0])
        else $error("held bit count out of range");

    // Last character clears the string state
    a_clear_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && item.is_last |=> len_reg == 2'd0 && held_reg == '0 &&
        err_reg == b64d_pkg::ERR_NONE && !pad_seen_reg)
        else $error("state not cleared after last character");

    // Once an error is stuck, the accumulator is frozen
    a_acc_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && !item.is_last && err_reg != b64d_pkg::ERR_NONE |=>
        acc_reg == $past(acc_reg))
        else $error("accumulator moved after character error");

endmodule

`default_nettype wire

/* sv/b64d_out_stage.sv */
// b64d_out_stage: result register of the decoder pipeline.
// Depends on b64d_pkg (result_t).
`timescale 1ns / 1ps
`default_nettype none

module b64d_out_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire b64d_pkg::result_t result,
    output logic                   advance,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output b64d_pkg::result_t      m_result
);

    logic              valid_reg, valid_next;
    b64d_pkg::result_t result_reg;

    // Register is free, or its request leaves this cycle
    assign advance    = !valid_reg || m_ready;
    assign valid_next = advance ? load : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

`default_nettype wire

/* sv/base64url_strict_decoder.sv */
// base64url_strict_decoder: streaming base64url decoder, one character per request.
// Each request passes the input register, then the result register, to its result on m_*.
// Throughput: 1 character per cycle while m_ready is high; set by the single decode step between
// the input register and the result register.
// Reset (aresetn low, synchronous): both stages empty, decode state cleared.
`timescale 1ns / 1ps
`default_nettype none

module base64url_strict_decoder (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input requests: one character each
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [b64d_pkg::CHAR_W-1:0]   s_char_code,
    input  wire logic                          s_is_last,
    // result requests: one per character
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_byte_valid,
    output logic [b64d_pkg::BYTE_W-1:0]        m_data_byte,
    output logic                               m_done_res,
    output logic [b64d_pkg::STATUS_W-1:0]      m_status
);

    b64d_pkg::item_t   s_item;
    b64d_pkg::item_t   item;
    logic              item_valid;
    logic              advance;
    logic              step_en;
    b64d_pkg::result_t result;
    b64d_pkg::result_t m_result;

    assign s_item.char_code = s_char_code;
    assign s_item.is_last   = s_is_last;

    // Input register: takes a new character whenever the held one moves on
    b64d_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Decode state advances exactly when its result enters the output register
    assign step_en = item_valid && advance;

    b64d_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (item),
        .result  (result)
    );

    // Output register separates downstream stalls from the decode step
    b64d_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (item_valid),
        .result   (result),
        .advance  (advance),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_byte_valid = m_result.byte_valid;
    assign m_data_byte  = m_result.data_byte;
    assign m_done_res   = m_result.done_res;
    assign m_status     = m_result.status;

    // Status is only reported on the last character's result
    a_status_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_done_res |-> m_status == b64d_pkg::STATUS_OK)
        else $error("status without done");

    // Idle byte slot reads zero
    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_valid |-> m_data_byte == '0)
        else $error("data byte without byte_valid");

    // A held input request moves to the output register when it is free
    a_no_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid && !m_valid |=> m_valid)
        else $error("decoded request lost");

endmodule

`default_nettype wire
